[rtl/lrb_pkg.sv]
// lrb_pkg: shared types, codes and reset constants of the link reconnect backoff block
// no dependencies; imported by every module in rtl/
package lrb_pkg;

    // event kinds
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_ACK  = 2'd1;
    localparam logic [1:0] MODE_LOST = 2'd2;

    // bring-up status
    localparam logic [1:0] BOOT_OK       = 2'd0;
    localparam logic [1:0] BOOT_INIT_ERR = 2'd1;

    // modem status
    localparam logic [1:0] MODEM_OFF   = 2'd0;
    localparam logic [1:0] MODEM_READY = 2'd2;

    // supervisor phase codes
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_OFFLINE  = 2'd1;
    localparam logic [1:0] PH_WAIT     = 2'd2;
    localparam logic [1:0] PH_COOLDOWN = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_OFFLINE_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_INITIAL_DELAY   = 3'd1;
    localparam logic [2:0] REG_BACKOFF_FACTOR  = 3'd2;
    localparam logic [2:0] REG_MAX_DELAY       = 3'd3;
    localparam logic [2:0] REG_RETRIES         = 3'd4;
    localparam logic [2:0] REG_MAX_REBOOTS     = 3'd5;
    localparam logic [2:0] REG_COOLDOWN        = 3'd6;
    localparam logic [2:0] REG_REOPEN_CHAN     = 3'd7;

    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [15:0] RST_OFFLINE_TIMEOUT = 16'd900;
    localparam logic [15:0] RST_INITIAL_DELAY   = 16'd30;
    localparam logic [3:0]  RST_BACKOFF_FACTOR  = 4'd2;
    localparam logic [15:0] RST_MAX_DELAY       = 16'd300;
    localparam logic [7:0]  RST_RETRIES         = 8'd3;
    localparam logic [7:0]  RST_MAX_REBOOTS     = 8'd3;
    localparam logic [15:0] RST_COOLDOWN        = 16'd600;
    localparam logic [2:0]  RST_REOPEN_CHAN     = 3'd0;

    typedef struct packed {
        logic [15:0] offline_timeout;
        logic [15:0] initial_delay;
        logic [3:0]  backoff_factor;
        logic [15:0] max_delay;
        logic [7:0]  retries_before_reboot;
        logic [7:0]  max_reboots;
        logic [15:0] cooldown_ticks;
        logic [2:0]  reopen_chan;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  phase;
        logic        online;
        logic [31:0] tick_count;
        logic [31:0] deadline;
        logic [15:0] retry_delay;
        logic [7:0]  open_tries;
        logic [7:0]  reboot_count;
        logic [15:0] silence_count;
    } t_state;

    typedef struct packed {
        logic       online;
        logic [1:0] phase;
        logic       want_poweron;
        logic       want_open;
        logic [2:0] open_channel;
        logic       want_reboot;
        logic       modem_reset;
        logic [7:0] attempts;
        logic [7:0] reboots;
    } t_result;

endpackage

[rtl/lrb_cfg_regs.sv]
// lrb_cfg_regs: configuration register file written through a plain write port
// depends on lrb_pkg
module lrb_cfg_regs
    import lrb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [2:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offline_timeout       <= RST_OFFLINE_TIMEOUT;
            r_cfg.initial_delay         <= RST_INITIAL_DELAY;
            r_cfg.backoff_factor        <= RST_BACKOFF_FACTOR;
            r_cfg.max_delay             <= RST_MAX_DELAY;
            r_cfg.retries_before_reboot <= RST_RETRIES;
            r_cfg.max_reboots           <= RST_MAX_REBOOTS;
            r_cfg.cooldown_ticks        <= RST_COOLDOWN;
            r_cfg.reopen_chan           <= RST_REOPEN_CHAN;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_OFFLINE_TIMEOUT: r_cfg.offline_timeout       <= i_cfg_wdata;
                REG_INITIAL_DELAY:   r_cfg.initial_delay         <= i_cfg_wdata;
                REG_BACKOFF_FACTOR:  r_cfg.backoff_factor        <= i_cfg_wdata[3:0];
                REG_MAX_DELAY:       r_cfg.max_delay             <= i_cfg_wdata;
                REG_RETRIES:         r_cfg.retries_before_reboot <= i_cfg_wdata[7:0];
                REG_MAX_REBOOTS:     r_cfg.max_reboots           <= i_cfg_wdata[7:0];
                REG_COOLDOWN:        r_cfg.cooldown_ticks        <= i_cfg_wdata;
                REG_REOPEN_CHAN:     r_cfg.reopen_chan           <= i_cfg_wdata[2:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/lrb_step.sv]
// lrb_step: next-state and result logic for one event of the supervisor
// depends on lrb_pkg; purely combinational
module lrb_step
    import lrb_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
) (
    input  t_state     i_st,
    input  t_cfg       i_cfg,
    input  logic [1:0] i_mode,
    input  logic [2:0] i_lost_channel,
    input  logic [1:0] i_boot_phase,
    input  logic [1:0] i_modem_ready,
    output t_state     o_st,
    output t_result    o_res
);

    localparam logic [3:0] LP_NCH = 4'(NUM_CHANNELS);

    logic [31:0] tick1;
    logic [15:0] sil1;
    logic [19:0] prod;
    logic [15:0] prod_lo;
    logic [15:0] backoff;
    logic [7:0]  att;
    logic [15:0] dly_add;
    logic        poweron, open, reboot, mreset;
    t_state      n;

    assign tick1   = i_st.tick_count + 32'd1;
    assign sil1    = (i_st.silence_count == 16'hFFFF) ? i_st.silence_count
                                                      : i_st.silence_count + 16'd1;
    assign prod    = i_st.retry_delay * {16'd0, i_cfg.backoff_factor};
    assign prod_lo = prod[15:0];

    // lower clamp wins over upper clamp
    always_comb begin
        if (prod_lo < i_cfg.initial_delay) begin
            backoff = i_cfg.initial_delay;
        end else if (prod_lo > i_cfg.max_delay) begin
            backoff = i_cfg.max_delay;
        end else begin
            backoff = prod_lo;
        end
    end

    always_comb begin
        n       = i_st;
        poweron = 1'b0;
        open    = 1'b0;
        reboot  = 1'b0;
        mreset  = 1'b0;
        att     = i_st.open_tries;
        dly_add = i_st.retry_delay;
        unique case (i_mode)
            MODE_TICK: begin
                n.tick_count = tick1;
                if (i_boot_phase != BOOT_INIT_ERR) begin
                    if (i_st.phase == PH_IDLE) begin
                        n.silence_count = sil1;
                        if (sil1 > i_cfg.offline_timeout) begin
                            n.online        = 1'b0;
                            n.phase         = PH_OFFLINE;
                            n.open_tries    = 8'd0;
                            n.retry_delay   = i_cfg.initial_delay;
                            n.deadline      = tick1 + {16'd0, i_cfg.initial_delay};
                        end
                    end else if (i_st.phase == PH_COOLDOWN) begin
                        if (tick1 >= i_st.deadline) begin
                            n.phase    = PH_WAIT;
                            n.deadline = tick1 + {16'd0, i_cfg.initial_delay};
                            poweron    = 1'b1;
                        end
                    end else if (tick1 >= i_st.deadline) begin
                        n.phase = PH_WAIT;
                        if (i_modem_ready == MODEM_OFF) begin
                            poweron = 1'b1;
                        end else if (i_modem_ready == MODEM_READY) begin
                            open          = 1'b1;
                            att           = (att == 8'hFF) ? att : att + 8'd1;
                            n.retry_delay = backoff;
                            dly_add       = backoff;
                        end
                        n.open_tries = att;
                        if (att >= i_cfg.retries_before_reboot &&
                            i_st.reboot_count < i_cfg.max_reboots) begin
                            reboot          = 1'b1;
                            mreset          = 1'b1;
                            n.reboot_count  = i_st.reboot_count + 8'd1;
                            n.open_tries    = 8'd0;
                            n.retry_delay   = i_cfg.initial_delay;
                            n.phase         = PH_COOLDOWN;
                            dly_add         = i_cfg.cooldown_ticks;
                        end
                        // deadline moves only on an open or a reboot
                        if (open || reboot) begin
                            n.deadline = tick1 + {16'd0, dly_add};
                        end
                    end
                end
            end
            MODE_ACK: begin
                n.online        = 1'b1;
                n.phase         = PH_IDLE;
                n.open_tries    = 8'd0;
                n.retry_delay   = i_cfg.initial_delay;
                n.silence_count = 16'd0;
            end
            MODE_LOST: begin
                if (({1'b0, i_lost_channel} < LP_NCH) && i_boot_phase == BOOT_OK) begin
                    n.online        = 1'b0;
                    n.phase         = PH_OFFLINE;
                    n.open_tries    = 8'd0;
                    n.retry_delay   = i_cfg.initial_delay;
                    n.deadline      = i_st.tick_count + {16'd0, i_cfg.initial_delay};
                    mreset          = 1'b1;
                end
            end
            default: begin
                // unused event kind: no change
            end
        endcase
    end

    assign o_st                = n;
    assign o_res.online        = n.online;
    assign o_res.phase         = n.phase;
    assign o_res.want_poweron  = poweron;
    assign o_res.want_open     = open;
    assign o_res.open_channel  = open ? i_cfg.reopen_chan : 3'd0;
    assign o_res.want_reboot   = reboot;
    assign o_res.modem_reset   = mreset;
    assign o_res.attempts      = n.open_tries;
    assign o_res.reboots       = n.reboot_count;

endmodule

[rtl/link_reconnect_backoff_fsm.sv]
// link_reconnect_backoff_fsm: top level of the link supervision state machine
// depends on lrb_pkg, lrb_cfg_regs and lrb_step
//
// The block takes one event transaction (tick, server ack or lost connection) and returns
// exactly one result transaction carrying the requested actions (power-on, channel open,
// modem reboot, modem reset) and the supervisor state after the event. It sustains one
// transaction per clock while the result side does not stall: an event is captured in an
// input register, the whole state update runs combinationally through the step logic,
// and the result lands in an output register. The clock rate is bounded by the
// combinational update path (a 16x4 multiply for the backoff step, the clamp and a
// 32-bit deadline add). A result stall holds the output register; the input register
// keeps accepting as long as its event can move on, and stalls only while it is full
// and the output register is held. Configuration registers are written through
// i_cfg_wr_en / i_cfg_idx / i_cfg_wdata and should only change while no transaction is
// in flight; a write never touches the running state such as the current retry delay.
module link_reconnect_backoff_fsm
    import lrb_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [2:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // event channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_mode,
    input  logic [2:0]            i_lost_channel,
    input  logic [1:0]            i_boot_phase,
    input  logic [1:0]            i_modem_ready,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_online,
    output logic [1:0]            o_phase,
    output logic                  o_want_poweron,
    output logic                  o_want_open,
    output logic [2:0]            o_open_channel,
    output logic                  o_want_reboot,
    output logic                  o_modem_reset,
    output logic [7:0]            o_attempts,
    output logic [7:0]            o_reboots
);

    t_cfg    cfg;
    t_state  r_st, n_st;
    t_result step_res;
    t_result r_res;

    // input register
    logic       r_in_valid;
    logic [1:0] r_mode;
    logic [2:0] r_lost_channel;
    logic [1:0] r_boot_phase;
    logic [1:0] r_modem_ready;

    logic r_out_valid;
    logic advance;   // input register moves into the output register
    logic in_take;   // event transaction accepted this cycle

    lrb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lrb_step #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_step (
        .i_st           (r_st),
        .i_cfg          (cfg),
        .i_mode         (r_mode),
        .i_lost_channel (r_lost_channel),
        .i_boot_phase   (r_boot_phase),
        .i_modem_ready  (r_modem_ready),
        .o_st           (n_st),
        .o_res          (step_res)
    );

    // output register free, or being emptied this cycle
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode         <= i_mode;
            r_lost_channel <= i_lost_channel;
            r_boot_phase   <= i_boot_phase;
            r_modem_ready  <= i_modem_ready;
        end
    end

    // supervisor state, committed when the event's result is registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase         <= PH_IDLE;
            r_st.online        <= 1'b0;
            r_st.tick_count    <= 32'd0;
            r_st.deadline      <= 32'd0;
            r_st.retry_delay   <= RST_INITIAL_DELAY;
            r_st.open_tries    <= 8'd0;
            r_st.reboot_count  <= 8'd0;
            r_st.silence_count <= 16'd0;
        end else if (advance) begin
            r_st <= n_st;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_online       = r_res.online;
    assign o_phase        = r_res.phase;
    assign o_want_poweron = r_res.want_poweron;
    assign o_want_open    = r_res.want_open;
    assign o_open_channel = r_res.open_channel;
    assign o_want_reboot  = r_res.want_reboot;
    assign o_modem_reset  = r_res.modem_reset;
    assign o_attempts     = r_res.attempts;
    assign o_reboots      = r_res.reboots;

`ifndef NO_ASSERTIONS
    // an open leaves the supervisor waiting for retry or in reboot cooldown
    a_open_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.want_open) |->
            (r_res.phase == PH_WAIT || r_res.phase == PH_COOLDOWN))
        else $error("open request outside wait or cooldown");

    // a reboot always resets the attempt count and enters cooldown
    a_reboot_cooldown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.want_reboot) |->
            (r_res.phase == PH_COOLDOWN && r_res.attempts == 8'd0 && r_res.modem_reset))
        else $error("reboot without cooldown entry");

    // the reboot count grows by at most one per event
    a_reboot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            (r_st.reboot_count == $past(r_st.reboot_count) ||
             r_st.reboot_count == $past(r_st.reboot_count) + 8'd1))
        else $error("reboot count jumped");

    // state only moves when an event is committed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_st))
        else $error("state changed without an event");
`endif

endmodule

[tb/link_reconnect_backoff_fsm_tb.sv]
// link_reconnect_backoff_fsm_tb: self-checking bench for the link supervision state machine
// depends on lrb_pkg and link_reconnect_backoff_fsm; scripted events first, then random
// phases, each result compared against a scripted value or an in-bench model of the supervisor
module link_reconnect_backoff_fsm_tb;
    import lrb_pkg::*;

    localparam int LINK_CHANNELS = 4;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    // codes the package leaves unnamed
    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam logic [1:0] BOOT_OTHER     = 2'd2;
    localparam logic [1:0] MODEM_POWERING = 2'd1;
    localparam logic [1:0] MODEM_BAD      = 2'd3;

    // settings table indexes
    localparam logic [3:0] CFG_DIRECTED   = 4'd0;
    localparam logic [3:0] CFG_TRUNC_SEED = 4'd1;
    localparam logic [3:0] CFG_TRUNC_WIDE = 4'd2;
    localparam logic [3:0] CFG_TRUNC_RUN  = 4'd3;
    localparam logic [3:0] CFG_FIRST_RAND = 4'd4;
    localparam logic [3:0] NO_CFG         = 4'hF;

    localparam int SCRIPT_ROWS = 25;
    localparam int PHASES      = 5;
    localparam int SOAK_PHASE  = 4;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] lost_channel;
        logic [1:0] boot_phase;
        logic [1:0] modem_ready;
    } t_event;

    // one scripted transaction: optional settings change before it, optional typed result
    typedef struct packed {
        t_event     ev;
        logic [3:0] cfg_before;
        logic       typed;
        t_result    want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_wr_en    = 1'b0;
    logic [2:0]            i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata    = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_mode         = '0;
    logic [2:0]            i_lost_channel = '0;
    logic [1:0]            i_boot_phase   = '0;
    logic [1:0]            i_modem_ready  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic                  o_online;
    logic [1:0]            o_phase;
    logic                  o_want_poweron;
    logic                  o_want_open;
    logic [2:0]            o_open_channel;
    logic                  o_want_reboot;
    logic                  o_modem_reset;
    logic [7:0]            o_attempts;
    logic [7:0]            o_reboots;

    link_reconnect_backoff_fsm #(
        .NUM_CHANNELS(LINK_CHANNELS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_lost_channel (i_lost_channel),
        .i_boot_phase   (i_boot_phase),
        .i_modem_ready  (i_modem_ready),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_online       (o_online),
        .o_phase        (o_phase),
        .o_want_poweron (o_want_poweron),
        .o_want_open    (o_want_open),
        .o_open_channel (o_open_channel),
        .o_want_reboot  (o_want_reboot),
        .o_modem_reset  (o_modem_reset),
        .o_attempts     (o_attempts),
        .o_reboots      (o_reboots)
    );

    // supervisor model state, kept beside the block
    t_cfg        cfg_now;
    logic [1:0]  sup_phase;
    logic        link_up;
    logic [31:0] tick_now;
    logic [31:0] deadline_at;
    logic [15:0] cur_delay;
    logic [7:0]  open_count;
    logic [7:0]  reboot_total;
    logic [15:0] silent_ticks;

    t_result     expected_status[$];
    t_result     status_rx;
    int          mismatches  = 0;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int unsigned cycle_count = 0;

    t_cfg cfg_sets[9];
    t_row script[SCRIPT_ROWS];

    // per-phase knobs of the random part
    int phase_idle[PHASES]  = '{0, 69, 0, 28, 0};
    int phase_stall[PHASES] = '{0, 0, 69, 28, 0};
    int phase_items[PHASES] = '{200, 200, 200, 200, 25};
    int phase_ack[PHASES]   = '{6, 6, 6, 6, 1};
    int phase_lost[PHASES]  = '{8, 8, 8, 8, 2};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case a result never shows up
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[link_reconnect_backoff_fsm] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    task automatic check_status(input t_result want);
        if (o_online !== want.online)
            report_mismatch("online", 32'(o_online), 32'(want.online));
        if (o_phase !== want.phase)
            report_mismatch("phase", 32'(o_phase), 32'(want.phase));
        if (o_want_poweron !== want.want_poweron)
            report_mismatch("want_poweron", 32'(o_want_poweron), 32'(want.want_poweron));
        if (o_want_open !== want.want_open)
            report_mismatch("want_open", 32'(o_want_open), 32'(want.want_open));
        if (o_open_channel !== want.open_channel)
            report_mismatch("open_channel", 32'(o_open_channel), 32'(want.open_channel));
        if (o_want_reboot !== want.want_reboot)
            report_mismatch("want_reboot", 32'(o_want_reboot), 32'(want.want_reboot));
        if (o_modem_reset !== want.modem_reset)
            report_mismatch("modem_reset", 32'(o_modem_reset), 32'(want.modem_reset));
        if (o_attempts !== want.attempts)
            report_mismatch("attempts", 32'(o_attempts), 32'(want.attempts));
        if (o_reboots !== want.reboots)
            report_mismatch("reboots", 32'(o_reboots), 32'(want.reboots));
    endtask

    // result side: check every accepted transaction, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_status.size() == 0) begin
                report_mismatch("result with nothing expected", 32'd0, 32'd0);
            end else begin
                status_rx = expected_status.pop_front();
                check_status(status_rx);
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic void drop_link();
        link_up     = 1'b0;
        sup_phase   = PH_OFFLINE;
        open_count  = '0;
        cur_delay   = cfg_now.initial_delay;
        deadline_at = tick_now + {16'd0, cur_delay};
    endfunction

    // advance the supervisor model by one event and return its status
    function automatic t_result supervise_event(input t_event ev);
        t_result     r;
        logic [19:0] prod;
        logic [15:0] grown;
        r = '0;
        case (ev.mode)
            MODE_TICK: begin
                tick_now = tick_now + 32'd1;
                // init error phase: only the tick counter moves
                if (ev.boot_phase != BOOT_INIT_ERR) begin
                    if (sup_phase == PH_IDLE) begin
                        if (silent_ticks != 16'hFFFF) silent_ticks++;
                        if (silent_ticks > cfg_now.offline_timeout) drop_link();
                    end else if (sup_phase == PH_COOLDOWN) begin
                        if (tick_now >= deadline_at) begin
                            sup_phase      = PH_WAIT;
                            deadline_at    = tick_now + {16'd0, cfg_now.initial_delay};
                            r.want_poweron = 1'b1;
                        end
                    end else if (tick_now >= deadline_at) begin
                        sup_phase = PH_WAIT;
                        if (ev.modem_ready == MODEM_OFF) begin
                            r.want_poweron = 1'b1;
                        end else if (ev.modem_ready == MODEM_READY) begin
                            r.want_open    = 1'b1;
                            r.open_channel = cfg_now.reopen_chan;
                            if (open_count != 8'hFF) open_count++;
                            // backoff step: multiply, keep 16 bits, lower clamp wins
                            prod  = {4'd0, cur_delay} * {16'd0, cfg_now.backoff_factor};
                            grown = prod[15:0];
                            if (grown < cfg_now.initial_delay)
                                cur_delay = cfg_now.initial_delay;
                            else if (grown > cfg_now.max_delay)
                                cur_delay = cfg_now.max_delay;
                            else
                                cur_delay = grown;
                            deadline_at = tick_now + {16'd0, cur_delay};
                        end
                        // reboot check runs whatever the modem said
                        if (open_count >= cfg_now.retries_before_reboot &&
                            reboot_total < cfg_now.max_reboots) begin
                            r.want_reboot = 1'b1;
                            r.modem_reset = 1'b1;
                            reboot_total++;
                            open_count    = '0;
                            cur_delay     = cfg_now.initial_delay;
                            sup_phase     = PH_COOLDOWN;
                            deadline_at   = tick_now + {16'd0, cfg_now.cooldown_ticks};
                        end
                    end
                end
            end
            MODE_ACK: begin
                link_up      = 1'b1;
                sup_phase    = PH_IDLE;
                open_count   = '0;
                cur_delay    = cfg_now.initial_delay;
                silent_ticks = '0;
            end
            MODE_LOST: begin
                if (int'(ev.lost_channel) < LINK_CHANNELS && ev.boot_phase == BOOT_OK) begin
                    drop_link();
                    r.modem_reset = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.online  = link_up;
        r.phase   = sup_phase;
        r.attempts = open_count;
        r.reboots = reboot_total;
        return r;
    endfunction

    // stop offering and wait until every result is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_status.size() != 0);
    endtask

    // settings change only with nothing in flight
    task automatic write_cfg(input t_cfg c);
        logic [CFG_DATA_W-1:0] word;
        wait_drained();
        repeat (3) @(posedge i_clk);
        for (int k = 0; k < 8; k++) begin
            case (k[2:0])
                REG_OFFLINE_TIMEOUT: word = c.offline_timeout;
                REG_INITIAL_DELAY:   word = c.initial_delay;
                REG_BACKOFF_FACTOR:  word = CFG_DATA_W'(c.backoff_factor);
                REG_MAX_DELAY:       word = c.max_delay;
                REG_RETRIES:         word = CFG_DATA_W'(c.retries_before_reboot);
                REG_MAX_REBOOTS:     word = CFG_DATA_W'(c.max_reboots);
                REG_COOLDOWN:        word = c.cooldown_ticks;
                default:             word = CFG_DATA_W'(c.reopen_chan);
            endcase
            i_cfg_wr_en <= 1'b1;
            i_cfg_idx   <= k[2:0];
            i_cfg_wdata <= word;
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        cfg_now = c;
    endtask

    // offer one event transaction, maybe after a gap, and log its expected status
    task automatic send_event(input t_event ev, input logic typed, input t_result typed_want);
        int      gap;
        t_result predicted;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= ev.mode;
        i_lost_channel <= ev.lost_channel;
        i_boot_phase   <= ev.boot_phase;
        i_modem_ready  <= ev.modem_ready;
        do @(posedge i_clk); while (o_in_stall);
        predicted = supervise_event(ev);
        expected_status.push_back(typed ? typed_want : predicted);
    endtask

    // mostly ticks with a healthy modem, so the retry and reboot paths get exercised
    function automatic t_event random_event(input int ack_pct, input int lost_pct);
        t_event ev;
        int     roll;
        roll = $urandom_range(99);
        if (roll < 3)                            ev.mode = MODE_UNUSED;
        else if (roll < 3 + ack_pct)             ev.mode = MODE_ACK;
        else if (roll < 3 + ack_pct + lost_pct)  ev.mode = MODE_LOST;
        else                                     ev.mode = MODE_TICK;
        ev.lost_channel = 3'($urandom_range(7));
        ev.boot_phase   = ($urandom_range(9) < 8) ? BOOT_OK : 2'($urandom_range(3));
        roll = $urandom_range(9);
        if (roll < 6)      ev.modem_ready = MODEM_READY;
        else if (roll < 8) ev.modem_ready = MODEM_OFF;
        else if (roll < 9) ev.modem_ready = MODEM_POWERING;
        else               ev.modem_ready = MODEM_BAD;
        return ev;
    endfunction

    initial begin
        t_event  ev;
        t_result idle_down;
        t_result idle_up;
        t_result went_down;

        // register values after reset
        cfg_now = '{RST_OFFLINE_TIMEOUT, RST_INITIAL_DELAY, RST_BACKOFF_FACTOR, RST_MAX_DELAY,
                    RST_RETRIES, RST_MAX_REBOOTS, RST_COOLDOWN, RST_REOPEN_CHAN};
        sup_phase    = PH_IDLE;
        link_up      = 1'b0;
        tick_now     = '0;
        deadline_at  = '0;
        cur_delay    = RST_INITIAL_DELAY;
        open_count   = '0;
        reboot_total = '0;
        silent_ticks = '0;

        // settings: timeout, initial, factor, max, retries, reboots, cooldown, channel
        cfg_sets[0] = '{16'd0, 16'd1, 4'd0, 16'd65535, 8'd2, 8'd1, 16'd0, 3'd7};
        cfg_sets[1] = '{16'd10, 16'd1, 4'd15, 16'd65535, 8'd0, 8'd255, 16'd0, 3'd5};
        cfg_sets[2] = '{16'd10, 16'd4400, 4'd15, 16'd65535, 8'd0, 8'd255, 16'd0, 3'd5};
        cfg_sets[3] = '{16'd10, 16'd1, 4'd15, 16'd65535, 8'd5, 8'd255, 16'd0, 3'd5};
        cfg_sets[4] = '{16'd5, 16'd2, 4'd2, 16'd40, 8'd3, 8'd2, 16'd3, 3'd1};
        cfg_sets[5] = '{16'd0, 16'd0, 4'd15, 16'd65535, 8'd0, 8'd255, 16'd0, 3'd7};
        // initial above max: the lower clamp wins
        cfg_sets[6] = '{16'd3, 16'd9, 4'd1, 16'd4, 8'd4, 8'd0, 16'd1, 3'd0};
        cfg_sets[7] = '{16'd2, 16'd3, 4'd7, 16'd50, 8'd255, 8'd255, 16'd65535, 3'd2};
        // zero delay, no reboots: attempts climb to saturation
        cfg_sets[8] = '{16'd65535, 16'd0, 4'd1, 16'd0, 8'd255, 8'd0, 16'd0, 3'd3};

        idle_down = '{1'b0, PH_IDLE, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 8'd0, 8'd0};
        idle_up   = '{1'b1, PH_IDLE, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 8'd0, 8'd0};
        went_down = '{1'b0, PH_OFFLINE, 1'b0, 1'b0, 3'd0, 1'b0, 1'b1, 8'd0, 8'd0};

        // reset values: a quiet tick, the unused mode, ack in any boot phase,
        // lost events that are ignored, then a real loss and a tick in init error
        script[0]  = '{'{MODE_TICK, 3'd0, BOOT_OK, MODEM_READY}, NO_CFG, 1'b1, idle_down};
        script[1]  = '{'{MODE_UNUSED, 3'd0, BOOT_OK, MODEM_READY}, NO_CFG, 1'b1, idle_down};
        script[2]  = '{'{MODE_ACK, 3'd0, BOOT_OTHER, MODEM_OFF}, NO_CFG, 1'b1, idle_up};
        script[3]  = '{'{MODE_LOST, 3'd7, BOOT_OK, MODEM_READY}, NO_CFG, 1'b1, idle_up};
        script[4]  = '{'{MODE_LOST, 3'd2, BOOT_INIT_ERR, MODEM_READY}, NO_CFG, 1'b1, idle_up};
        script[5]  = '{'{MODE_LOST, 3'd3, BOOT_OK, MODEM_BAD}, NO_CFG, 1'b1, went_down};
        script[6]  = '{'{MODE_TICK, 3'd0, BOOT_INIT_ERR, MODEM_READY}, NO_CFG, 1'b1,
                       '{1'b0, PH_OFFLINE, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 8'd0, 8'd0}};
        // short delays, zero factor: powering up, power-on, two opens, reboot,
        // cooldown expiry, bad modem code, reboot limit reached, timeout of zero
        script[7]  = '{'{MODE_LOST, 3'd0, BOOT_OK, MODEM_READY}, CFG_DIRECTED, 1'b0, '0};
        script[8]  = '{'{MODE_TICK, 3'd0, BOOT_OK, MODEM_POWERING}, NO_CFG, 1'b0, '0};
        script[9]  = '{'{MODE_TICK, 3'd0, BOOT_OK, MODEM_OFF}, NO_CFG, 1'b0, '0};
        script[10] = '{'{MODE_TICK, 3'd0, BOOT_OK, MODEM_READY}, NO_CFG, 1'b0, '0};
        script[11] = '{'{MODE_TICK, 3'd0, BOOT_OK, MODEM_READY}, NO_CFG, 1'b0, '0};
        script[12] = '{'{MODE_TICK, 3'd0, BOOT_OK, MODEM_READY}, NO_CFG, 1'b0, '0};
        script[13] = '{'{MODE_TICK, 3'd0, BOOT_OK, MODEM_BAD}, NO_CFG, 1'b0, '0};
        script[14] = '{'{MODE_TICK, 3'd0, BOOT_OK, MODEM_READY}, NO_CFG, 1'b0, '0};
        script[15] = '{'{MODE_TICK, 3'd0, BOOT_OK, MODEM_READY}, NO_CFG, 1'b0, '0};
        script[16] = '{'{MODE_ACK, 3'd0, BOOT_OK, MODEM_READY}, NO_CFG, 1'b0, '0};
        script[17] = '{'{MODE_TICK, 3'd0, BOOT_OTHER, MODEM_READY}, NO_CFG, 1'b0, '0};
        script[18] = '{'{MODE_LOST, 3'd3, BOOT_OTHER, MODEM_READY}, NO_CFG, 1'b0, '0};
        script[19] = '{'{MODE_ACK, 3'd0, BOOT_INIT_ERR, MODEM_READY}, NO_CFG, 1'b0, '0};
        // 16-bit truncation: reboot loads a large delay, then a small initial
        // delay ends the cooldown fast so the next open multiplies it
        script[20] = '{'{MODE_LOST, 3'd1, BOOT_OK, MODEM_READY}, CFG_TRUNC_SEED, 1'b0, '0};
        script[21] = '{'{MODE_TICK, 3'd0, BOOT_OK, MODEM_POWERING}, CFG_TRUNC_WIDE, 1'b0, '0};
        script[22] = '{'{MODE_TICK, 3'd0, BOOT_OK, MODEM_READY}, CFG_TRUNC_RUN, 1'b0, '0};
        script[23] = '{'{MODE_TICK, 3'd0, BOOT_OK, MODEM_READY}, NO_CFG, 1'b0, '0};
        script[24] = '{'{MODE_ACK, 3'd0, BOOT_OK, MODEM_READY}, NO_CFG, 1'b0, '0};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // scripted part
        for (int k = 0; k < SCRIPT_ROWS; k++) begin
            if (script[k].cfg_before != NO_CFG) write_cfg(cfg_sets[script[k].cfg_before]);
            send_event(script[k].ev, script[k].typed, script[k].want);
        end

        // random phases, one settings change and one idle pattern each
        for (int p = 0; p < PHASES; p++) begin
            write_cfg(cfg_sets[CFG_FIRST_RAND + p]);
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            if (p == SOAK_PHASE) begin
                // an open on every tick until the attempt counter saturates
                ev = '{MODE_LOST, 3'd0, BOOT_OK, MODEM_READY};
                send_event(ev, 1'b0, '0);
                ev = '{MODE_TICK, 3'd0, BOOT_OK, MODEM_READY};
                for (int k = 0; k < 300; k++)
                    send_event(ev, 1'b0, '0);
            end
            for (int k = 0; k < phase_items[p]; k++) begin
                // now and then hold off until the result side has caught up
                if ($urandom_range(39) == 0) wait_drained();
                ev = random_event(phase_ack[p], phase_lost[p]);
                send_event(ev, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("[link_reconnect_backoff_fsm] OK");
        else
            $display("[link_reconnect_backoff_fsm] ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/lrb_pkg.sv
rtl/lrb_cfg_regs.sv
rtl/lrb_step.sv
rtl/link_reconnect_backoff_fsm.sv
tb/link_reconnect_backoff_fsm_tb.sv
